@@ rtl/h2r_pkg.sv @@
package h2r_pkg;

  // Default number of fraction bits in the internal fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Number of register stages in the conversion pipeline.
  localparam int PIPE_STAGES = 7;

  // Saturation and lightness at 1.0 on the input side.
  localparam logic [16:0] IN_ONE = 17'h10000;

  // Sextant codes; each picks an order of top, mid and bottom values.
  localparam logic [2:0] SEXT_RED_YEL = 3'd0;
  localparam logic [2:0] SEXT_YEL_GRN = 3'd1;
  localparam logic [2:0] SEXT_GRN_CYN = 3'd2;
  localparam logic [2:0] SEXT_CYN_BLU = 3'd3;
  localparam logic [2:0] SEXT_BLU_MAG = 3'd4;

  // Per-stage load enables and occupancy flags of the pipeline.
  typedef struct packed {
    logic [PIPE_STAGES-1:0] load;
    logic [PIPE_STAGES-1:0] valid;
  } pipe_ctrl_t;

endpackage

@@ rtl/h2r_pipe_ctrl.sv @@
module h2r_pipe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output h2r_pkg::pipe_ctrl_t ctrl
);

  localparam int N = h2r_pkg::PIPE_STAGES;

  logic [N-1:0] valid;
  logic [N-1:0] load;

  // A stage may load when it is empty or when its content moves on.
  always_comb begin
    load[N-1] = !valid[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      load[i] = !valid[i] || load[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= (valid & ~load) | ({valid[N-2:0], in_valid} & load);
    end
  end

  assign in_ready   = load[0];
  assign out_valid  = valid[N-1];
  assign ctrl.load  = load;
  assign ctrl.valid = valid;

  // An empty output stage must never hold off the input side.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !valid[N-1] |-> in_ready)
    else $error("input stalled while pipeline output stage is empty");

  // A transfer on the input side must occupy the first stage.
  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> valid[0])
    else $error("accepted pixel did not enter the first stage");

endmodule

@@ rtl/hsl_to_rgb_pixel.sv @@
// Seven register stages, each holding one pixel, which moves through them in order.
// Throughput: one pixel per clock while out_ready stays high.
// Back pressure stalls only the stages that are full, so bubbles are squeezed out.
// Reset (rst, synchronous, active high) empties every stage; data registers are not reset.
// There is no configuration and no state kept between pixels.
module hsl_to_rgb_pixel #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] hue,
  input  logic [16:0] saturation,
  input  logic [16:0] lightness,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  // Saturation and lightness carry FRAC_BITS fraction bits and one integer
  // bit, so 1.0 fits exactly. The top and bottom values get one more bit of
  // headroom for the intermediate sums.
  localparam int FW    = FRAC_BITS + 1;
  localparam int VW    = FRAC_BITS + 2;
  localparam int SH_L  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_R  = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
  localparam int WW    = 17 + SH_L;
  localparam int PW    = 2 * FW;
  localparam int DPW   = VW + 16;
  localparam int TW    = VW + 8;
  localparam int BW    = TW - FRAC_BITS;
  localparam logic [FW-1:0] HALF = FW'(1) << (FRAC_BITS - 1);

  h2r_pkg::pipe_ctrl_t ctrl;

  h2r_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  // ---------------------------------------------------------------------
  // Stage 1: clamp saturation and lightness to 1.0, move them to the
  // internal format, and split hue*6 into a sextant and a 16-bit fraction.
  // hue*6 is formed as hue*4 + hue*2, so no multiplier is needed here.
  // ---------------------------------------------------------------------
  logic [16:0]   sat_clamp;
  logic [16:0]   lit_clamp;
  logic [WW-1:0] sat_wide;
  logic [WW-1:0] lit_wide;
  logic [18:0]   hue6;

  always_comb begin
    sat_clamp = (saturation > h2r_pkg::IN_ONE) ? h2r_pkg::IN_ONE : saturation;
    lit_clamp = (lightness > h2r_pkg::IN_ONE) ? h2r_pkg::IN_ONE : lightness;
    sat_wide  = WW'(sat_clamp) << SH_L;
    lit_wide  = WW'(lit_clamp) << SH_L;
    hue6      = (19'(hue) << 2) + (19'(hue) << 1);
  end

  logic [FW-1:0] s1_sat;
  logic [FW-1:0] s1_lit;
  logic [2:0]    s1_sext;
  logic [15:0]   s1_frac;

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s1_sat  <= FW'(sat_wide >> SH_R);
      s1_lit  <= FW'(lit_wide >> SH_R);
      s1_sext <= hue6[18:16];
      s1_frac <= hue6[15:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: the multiply l*s, truncated to FRAC_BITS
  // fraction bits. The product never exceeds 1.0.
  // ---------------------------------------------------------------------
  logic [PW-1:0] ls_prod;

  assign ls_prod = PW'(s1_lit) * PW'(s1_sat);

  logic [FW-1:0] s2_ls;
  logic [FW-1:0] s2_sat;
  logic [FW-1:0] s2_lit;
  logic [2:0]    s2_sext;
  logic [15:0]   s2_frac;

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      s2_ls   <= ls_prod[FRAC_BITS +: FW];
      s2_sat  <= s1_sat;
      s2_lit  <= s1_lit;
      s2_sext <= s1_sext;
      s2_frac <= s1_frac;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: top value. Dark colors (l at most one half) use l + l*s, light
  // colors use l + s - l*s.
  // ---------------------------------------------------------------------
  logic [VW-1:0] top_next;

  always_comb begin
    if (s2_lit <= HALF) begin
      top_next = VW'(s2_lit) + VW'(s2_ls);
    end else begin
      top_next = VW'(s2_lit) + VW'(s2_sat) - VW'(s2_ls);
    end
  end

  logic [VW-1:0] s3_top;
  logic [FW-1:0] s3_lit;
  logic [2:0]    s3_sext;
  logic [15:0]   s3_frac;

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      s3_top  <= top_next;
      s3_lit  <= s2_lit;
      s3_sext <= s2_sext;
      s3_frac <= s2_frac;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: bottom value m = 2l - v, held between zero and v, and the span
  // v - m. The span is worked out in parallel with m (as 2v - 2l) so that
  // the multiply in the next stage starts from a register.
  // ---------------------------------------------------------------------
  logic [VW-1:0] twice_lit;
  logic [VW:0]   twice_top;
  logic [VW-1:0] bot_next;
  logic [VW-1:0] span_next;

  always_comb begin
    twice_lit = {s3_lit, 1'b0};
    twice_top = {s3_top, 1'b0};
    if (twice_lit < s3_top) begin
      bot_next  = '0;
      span_next = s3_top;
    end else if ((VW+1)'(twice_lit) > twice_top) begin
      bot_next  = s3_top;
      span_next = '0;
    end else begin
      bot_next  = twice_lit - s3_top;
      span_next = VW'(twice_top - (VW+1)'(twice_lit));
    end
  end

  logic [VW-1:0] s4_top;
  logic [VW-1:0] s4_bot;
  logic [VW-1:0] s4_span;
  logic          s4_black;
  logic [2:0]    s4_sext;
  logic [15:0]   s4_frac;

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      s4_top   <= s3_top;
      s4_bot   <= bot_next;
      s4_span  <= span_next;
      s4_black <= (s3_top == '0);
      s4_sext  <= s3_sext;
      s4_frac  <= s3_frac;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: the ramp (v - m) * fraction, truncated to the span's scale.
  // ---------------------------------------------------------------------
  logic [DPW-1:0] ramp_prod;

  assign ramp_prod = DPW'(s4_span) * DPW'(s4_frac);

  logic [VW-1:0] s5_top;
  logic [VW-1:0] s5_bot;
  logic [VW-1:0] s5_ramp;
  logic          s5_black;
  logic [2:0]    s5_sext;

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      s5_top   <= s4_top;
      s5_bot   <= s4_bot;
      s5_ramp  <= ramp_prod[16 +: VW];
      s5_black <= s4_black;
      s5_sext  <= s4_sext;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: the rising and falling mid values, and the channel order that
  // the sextant picks. A zero top value forces black.
  // ---------------------------------------------------------------------
  logic [VW-1:0] mid_up;
  logic [VW-1:0] mid_down;
  logic [VW-1:0] red_next;
  logic [VW-1:0] green_next;
  logic [VW-1:0] blue_next;

  always_comb begin
    mid_up   = s5_bot + s5_ramp;
    mid_down = s5_top - s5_ramp;
    case (s5_sext)
      h2r_pkg::SEXT_RED_YEL: begin
        red_next = s5_top;   green_next = mid_up;   blue_next = s5_bot;
      end
      h2r_pkg::SEXT_YEL_GRN: begin
        red_next = mid_down; green_next = s5_top;   blue_next = s5_bot;
      end
      h2r_pkg::SEXT_GRN_CYN: begin
        red_next = s5_bot;   green_next = s5_top;   blue_next = mid_up;
      end
      h2r_pkg::SEXT_CYN_BLU: begin
        red_next = s5_bot;   green_next = mid_down; blue_next = s5_top;
      end
      h2r_pkg::SEXT_BLU_MAG: begin
        red_next = mid_up;   green_next = s5_bot;   blue_next = s5_top;
      end
      default: begin
        red_next = s5_top;   green_next = s5_bot;   blue_next = mid_down;
      end
    endcase
    if (s5_black) begin
      red_next   = '0;
      green_next = '0;
      blue_next  = '0;
    end
  end

  logic [VW-1:0] s6_chan [3];

  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      s6_chan[0] <= red_next;
      s6_chan[1] <= green_next;
      s6_chan[2] <= blue_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: scale each channel to a byte as (c*255) >> FRAC_BITS, formed
  // as c*256 - c, and saturate at 255. These are the output registers.
  // ---------------------------------------------------------------------
  logic [TW-1:0] scaled [3];
  logic [BW-1:0] byte_wide [3];
  logic [7:0]    byte_next [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      scaled[k]    = (TW'(s6_chan[k]) << 8) - TW'(s6_chan[k]);
      byte_wide[k] = scaled[k][FRAC_BITS +: BW];
      byte_next[k] = (byte_wide[k] > BW'(255)) ? 8'hFF : byte_wide[k][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[6]) begin
      red   <= byte_next[0];
      green <= byte_next[1];
      blue  <= byte_next[2];
    end
  end

  // The bottom value must never rise above the top value, and the span must equal their difference.
  a_bot_below_top: assert property (@(posedge clk) disable iff (rst)
    ctrl.valid[3] |-> (s4_bot <= s4_top) && (VW'(s4_top - s4_bot) == s4_span))
    else $error("bottom value or span inconsistent with top value");

  // The ramp stays inside the span, so both mid values lie between m and v.
  a_ramp_in_span: assert property (@(posedge clk) disable iff (rst)
    ctrl.valid[4] |-> (s5_ramp <= VW'(s5_top - s5_bot)))
    else $error("ramp exceeds the span between bottom and top values");

endmodule
